// File: rtl/spvd_pkg.sv
// ----------------------------------------------------------------------------
// spvd_pkg - shared definitions for the step peak/valley detector
// register map, register widths and reset values, phase codes and helpers
// ----------------------------------------------------------------------------
package spvd_pkg;

    // default build parameters
    localparam int WINDOW_LEN_DEF  = 15;
    localparam int SAMPLE_BITS_DEF = 13;

    // lobe and flat-run counters
    localparam int              CNT_W    = 16;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam int              FLAT_END = 4;

    // configuration port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_SLOPE_THR     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_MIN_LOBE_LEN  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_MAX_LOBE_LEN  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_MIN_TOTAL_LEN = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_MIN_LOBE_AREA = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_MIN_SUM_AREA  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_MIN_PEAK      = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_QUIET_LIMIT   = 3'd7;

    localparam int W_SLOPE_THR     = 8;
    localparam int W_MIN_LOBE_LEN  = 16;
    localparam int W_MAX_LOBE_LEN  = 16;
    localparam int W_MIN_TOTAL_LEN = 17;
    localparam int W_MIN_LOBE_AREA = 30;
    localparam int W_MIN_SUM_AREA  = 31;
    localparam int W_MIN_PEAK      = 14;
    localparam int W_QUIET_LIMIT   = 16;

    localparam logic [W_SLOPE_THR-1:0]     RST_SLOPE_THR     = 8'd5;
    localparam logic [W_MIN_LOBE_LEN-1:0]  RST_MIN_LOBE_LEN  = 16'd3;
    localparam logic [W_MAX_LOBE_LEN-1:0]  RST_MAX_LOBE_LEN  = 16'd100;
    localparam logic [W_MIN_TOTAL_LEN-1:0] RST_MIN_TOTAL_LEN = 17'd10;
    localparam logic [W_MIN_LOBE_AREA-1:0] RST_MIN_LOBE_AREA = 30'd50;
    localparam logic [W_MIN_SUM_AREA-1:0]  RST_MIN_SUM_AREA  = 31'd150;
    localparam logic [W_MIN_PEAK-1:0]      RST_MIN_PEAK      = 14'd5;
    localparam logic [W_QUIET_LIMIT-1:0]   RST_QUIET_LIMIT   = 16'd20;

    // detector phases, one-hot
    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_RISE  = 5'b00010,
        PH_QUIET = 5'b00100,
        PH_FALL  = 5'b01000,
        PH_JUDGE = 5'b10000
    } t_phase;

    // saturating counter increment
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

endpackage

// File: rtl/step_peak_valley_detector_unit.sv
// ----------------------------------------------------------------------------
// step_peak_valley_detector_unit - pedometer step detector
// moving average, deadzoned slope and a rise/quiet/fall lobe tracker that
// flags one step per qualifying rising and falling lobe pair
// ----------------------------------------------------------------------------
// One beat in, one beat out: every filtered magnitude sample yields one
// result beat carrying the deadzoned slope of the moving average and a step
// flag. A sample is accepted in every cycle unless the input stalls and
// runs through a five-stage pipeline (window sum, constant-reciprocal
// divide, phase tracker, lobe area multiply, threshold compare into the
// output register); the sustained rate is one beat per cycle while the
// output does not stall. A stall on the output backs up stage by stage, so
// the input only stalls once all five stages hold a beat. Thresholds sit in
// eight APB registers at byte address 4*index and are expected to change
// only while no beat is in flight. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module step_peak_valley_detector_unit
    import spvd_pkg::*;
#(
    parameter int WINDOW_LEN  = WINDOW_LEN_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // sample input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_fir_output,
    // result output channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_step_detected,
    output logic signed [SAMPLE_BITS:0]   o_slope_out,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [APB_ADDR_W-1:0]         paddr,
    input  logic [APB_DATA_W-1:0]         pwdata,
    output logic [APB_DATA_W-1:0]         prdata,
    output logic                          pready
);

    // derived widths
    localparam int LOG_W   = $clog2(WINDOW_LEN);
    localparam int SUM_W   = SAMPLE_BITS + LOG_W;      // signed running sum
    localparam int SHIFT   = SUM_W + LOG_W;            // reciprocal scale
    localparam int PROD_W  = 2 * SUM_W + 1;
    localparam int SLOPE_W = SAMPLE_BITS + 1;          // signed slope
    localparam int KW      = SLOPE_W + 1;              // slope vs threshold
    localparam int PEAK_W  = SAMPLE_BITS;              // peak magnitude
    localparam int AREA_W  = CNT_W + PEAK_W;
    localparam int TOT_W   = W_MIN_TOTAL_LEN;
    localparam int CMP_A_W = (AREA_W + 1 > W_MIN_SUM_AREA) ? AREA_W + 1 : W_MIN_SUM_AREA;
    localparam int CMP_P_W = (PEAK_W > W_MIN_PEAK) ? PEAK_W : W_MIN_PEAK;

    // ceil(2^SHIFT / WINDOW_LEN): exact floor division for every sum magnitude
    localparam logic [SUM_W:0] RECIP = (SUM_W + 1)'(((64'd1 << SHIFT)
                                       + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

    localparam logic signed [SLOPE_W-1:0] K_ONE       = SLOPE_W'(1);
    localparam logic signed [SLOPE_W-1:0] K_MINUS_ONE = SLOPE_W'(-1);

    // ------------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------------
    logic [W_SLOPE_THR-1:0]     r_cfg_slope_thr;
    logic [W_MIN_LOBE_LEN-1:0]  r_cfg_min_lobe_len;
    logic [W_MAX_LOBE_LEN-1:0]  r_cfg_max_lobe_len;
    logic [W_MIN_TOTAL_LEN-1:0] r_cfg_min_total_len;
    logic [W_MIN_LOBE_AREA-1:0] r_cfg_min_lobe_area;
    logic [W_MIN_SUM_AREA-1:0]  r_cfg_min_sum_area;
    logic [W_MIN_PEAK-1:0]      r_cfg_min_peak;
    logic [W_QUIET_LIMIT-1:0]   r_cfg_quiet_limit;

    logic                 w_cfg_wr;
    logic [REG_IDX_W-1:0] w_cfg_idx;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    // word index, byte lane bits ignored
    assign w_cfg_idx = paddr[APB_ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_slope_thr     <= RST_SLOPE_THR;
            r_cfg_min_lobe_len  <= RST_MIN_LOBE_LEN;
            r_cfg_max_lobe_len  <= RST_MAX_LOBE_LEN;
            r_cfg_min_total_len <= RST_MIN_TOTAL_LEN;
            r_cfg_min_lobe_area <= RST_MIN_LOBE_AREA;
            r_cfg_min_sum_area  <= RST_MIN_SUM_AREA;
            r_cfg_min_peak      <= RST_MIN_PEAK;
            r_cfg_quiet_limit   <= RST_QUIET_LIMIT;
        end else if (w_cfg_wr) begin
            case (w_cfg_idx)
                REG_SLOPE_THR:     r_cfg_slope_thr     <= pwdata[W_SLOPE_THR-1:0];
                REG_MIN_LOBE_LEN:  r_cfg_min_lobe_len  <= pwdata[W_MIN_LOBE_LEN-1:0];
                REG_MAX_LOBE_LEN:  r_cfg_max_lobe_len  <= pwdata[W_MAX_LOBE_LEN-1:0];
                REG_MIN_TOTAL_LEN: r_cfg_min_total_len <= pwdata[W_MIN_TOTAL_LEN-1:0];
                REG_MIN_LOBE_AREA: r_cfg_min_lobe_area <= pwdata[W_MIN_LOBE_AREA-1:0];
                REG_MIN_SUM_AREA:  r_cfg_min_sum_area  <= pwdata[W_MIN_SUM_AREA-1:0];
                REG_MIN_PEAK:      r_cfg_min_peak      <= pwdata[W_MIN_PEAK-1:0];
                REG_QUIET_LIMIT:   r_cfg_quiet_limit   <= pwdata[W_QUIET_LIMIT-1:0];
                default: ;
            endcase
        end
    end

    // register readback, zero extended
    always_comb begin
        case (w_cfg_idx)
            REG_SLOPE_THR:     prdata = APB_DATA_W'(r_cfg_slope_thr);
            REG_MIN_LOBE_LEN:  prdata = APB_DATA_W'(r_cfg_min_lobe_len);
            REG_MAX_LOBE_LEN:  prdata = APB_DATA_W'(r_cfg_max_lobe_len);
            REG_MIN_TOTAL_LEN: prdata = APB_DATA_W'(r_cfg_min_total_len);
            REG_MIN_LOBE_AREA: prdata = APB_DATA_W'(r_cfg_min_lobe_area);
            REG_MIN_SUM_AREA:  prdata = APB_DATA_W'(r_cfg_min_sum_area);
            REG_MIN_PEAK:      prdata = APB_DATA_W'(r_cfg_min_peak);
            REG_QUIET_LIMIT:   prdata = APB_DATA_W'(r_cfg_quiet_limit);
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // pipeline flow control: a stage takes a beat when it is empty or its
    // current beat moves on in the same cycle
    // ------------------------------------------------------------------------
    logic r_v1, r_v2, r_v3, r_v4, r_out_valid;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_rdy5;
    logic w_accept, w_mv12, w_mv23, w_mv34, w_mv45;

    assign w_rdy5 = !r_out_valid || !i_out_stall;
    assign w_rdy4 = !r_v4 || w_rdy5;
    assign w_rdy3 = !r_v3 || w_rdy4;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;

    assign o_in_stall = !w_rdy1;
    assign w_accept   = i_in_valid && w_rdy1;
    assign w_mv12     = r_v1 && w_rdy2;
    assign w_mv23     = r_v2 && w_rdy3;
    assign w_mv34     = r_v3 && w_rdy4;
    assign w_mv45     = r_v4 && w_rdy5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_rdy1) r_v1        <= i_in_valid;
            if (w_rdy2) r_v2        <= r_v1;
            if (w_rdy3) r_v3        <= r_v2;
            if (w_rdy4) r_v4        <= r_v3;
            if (w_rdy5) r_out_valid <= r_v4;
        end
    end

    assign o_out_valid = r_out_valid;

    // ------------------------------------------------------------------------
    // stage 1: sample window and running sum
    // the sum register is both the window state and this stage's payload
    // ------------------------------------------------------------------------
    logic signed [SAMPLE_BITS-1:0] r_taps [WINDOW_LEN];
    logic signed [SUM_W-1:0]       r_sum;
    logic signed [SUM_W-1:0]       n_sum;

    assign n_sum = r_sum - SUM_W'(r_taps[0]) + SUM_W'(i_fir_output);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW_LEN; i++) begin
                r_taps[i] <= '0;
            end
            r_sum <= '0;
        end else if (w_accept) begin
            // oldest sample leaves at tap 0, newest enters at the top
            for (int i = 0; i < WINDOW_LEN - 1; i++) begin
                r_taps[i] <= r_taps[i+1];
            end
            r_taps[WINDOW_LEN-1] <= i_fir_output;
            r_sum                <= n_sum;
        end
    end

    // ------------------------------------------------------------------------
    // stage 2: average = sum / WINDOW_LEN, truncated toward zero
    // divide the magnitude by reciprocal multiply, then restore the sign
    // ------------------------------------------------------------------------
    logic                          w_sum_neg;
    logic [SUM_W-1:0]              w_sum_mag;
    logic [PROD_W-1:0]             w_quot_prod;
    logic [SAMPLE_BITS-1:0]        w_quot;
    logic signed [SAMPLE_BITS-1:0] n_avg;
    logic signed [SAMPLE_BITS-1:0] r_avg;

    assign w_sum_neg   = r_sum[SUM_W-1];
    assign w_sum_mag   = w_sum_neg ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign w_quot_prod = PROD_W'(w_sum_mag) * PROD_W'(RECIP);
    assign w_quot      = w_quot_prod[SHIFT +: SAMPLE_BITS];
    assign n_avg       = w_sum_neg ? $signed(-w_quot) : $signed(w_quot);

    always_ff @(posedge i_clk) begin
        if (w_mv12) begin
            r_avg <= n_avg;
        end
    end

    // ------------------------------------------------------------------------
    // stage 3: slope, deadzone and lobe tracking
    // ------------------------------------------------------------------------
    t_phase                    r_phase, n_phase;
    logic signed [SAMPLE_BITS-1:0] r_prev_avg;
    logic [CNT_W-1:0]          r_rise_len, n_rise_len;
    logic [CNT_W-1:0]          r_fall_len, n_fall_len;
    logic [CNT_W-1:0]          r_flat_count, n_flat_count;
    logic signed [SLOPE_W-1:0] r_rise_peak, n_rise_peak;
    logic signed [SLOPE_W-1:0] r_fall_peak, n_fall_peak;

    logic signed [SLOPE_W-1:0] w_k_raw, w_k, w_fall_mag;
    logic signed [KW-1:0]      w_kx, w_thr;
    logic                      w_rising, w_falling;

    assign w_k_raw = SLOPE_W'(r_avg) - SLOPE_W'(r_prev_avg);
    // a change of one count is treated as no change
    assign w_k     = (w_k_raw == K_ONE || w_k_raw == K_MINUS_ONE) ? '0 : w_k_raw;

    assign w_kx      = KW'(w_k);
    assign w_thr     = KW'(r_cfg_slope_thr);
    // with a zero threshold a zero slope counts as both
    assign w_rising  = w_kx >= w_thr;
    assign w_falling = w_kx <= -w_thr;

    always_comb begin
        n_phase      = r_phase;
        n_rise_len   = r_rise_len;
        n_fall_len   = r_fall_len;
        n_flat_count = r_flat_count;
        n_rise_peak  = r_rise_peak;
        n_fall_peak  = r_fall_peak;
        case (r_phase)
            PH_IDLE: begin
                // start of rise is not counted in the lobe length
                n_rise_len   = '0;
                n_fall_len   = '0;
                n_flat_count = '0;
                n_rise_peak  = '0;
                n_fall_peak  = '0;
                if (w_rising) n_phase = PH_RISE;
            end
            PH_RISE: begin
                if (w_rising) begin
                    n_rise_len = sat_inc(r_rise_len);
                    if (w_k > r_rise_peak) n_rise_peak = w_k;
                end else if (!w_falling) begin
                    n_rise_len   = sat_inc(r_rise_len);
                    n_flat_count = sat_inc(r_flat_count);
                    if (n_flat_count > CNT_W'(FLAT_END)) n_phase = PH_QUIET;
                end else begin
                    n_phase = PH_FALL;
                end
            end
            PH_QUIET: begin
                if (!w_rising && !w_falling) begin
                    n_flat_count = sat_inc(r_flat_count);
                    if (n_flat_count > r_cfg_quiet_limit) n_phase = PH_IDLE;
                end else if (w_rising) begin
                    n_phase = PH_IDLE;
                end else begin
                    n_flat_count = '0;
                    n_phase      = PH_FALL;
                end
            end
            PH_FALL: begin
                if (w_falling && !w_rising) begin
                    n_fall_len = sat_inc(r_fall_len);
                    if (w_k < r_fall_peak) n_fall_peak = w_k;
                end else if (!w_rising && !w_falling) begin
                    n_fall_len   = sat_inc(r_fall_len);
                    n_flat_count = sat_inc(r_flat_count);
                    if (n_flat_count > CNT_W'(FLAT_END)) n_phase = PH_JUDGE;
                end else begin
                    n_phase = PH_JUDGE;
                end
            end
            PH_JUDGE: begin
                // slope of this beat is ignored, the lobes are judged
                n_phase = PH_IDLE;
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_prev_avg   <= '0;
            r_rise_len   <= '0;
            r_fall_len   <= '0;
            r_flat_count <= '0;
            r_rise_peak  <= '0;
            r_fall_peak  <= '0;
        end else if (w_mv23) begin
            r_phase      <= n_phase;
            r_prev_avg   <= r_avg;
            r_rise_len   <= n_rise_len;
            r_fall_len   <= n_fall_len;
            r_flat_count <= n_flat_count;
            r_rise_peak  <= n_rise_peak;
            r_fall_peak  <= n_fall_peak;
        end
    end

    // lobe snapshot for the judge, taken before the next idle beat clears it
    logic signed [SLOPE_W-1:0] r_s3_k;
    logic                      r_s3_judge;
    logic [CNT_W-1:0]          r_s3_rise_len, r_s3_fall_len;
    logic [PEAK_W-1:0]         r_s3_rise_peak, r_s3_fall_peak;

    // peaks are never of the wrong sign, so the magnitudes fit PEAK_W bits
    assign w_fall_mag = -r_fall_peak;

    always_ff @(posedge i_clk) begin
        if (w_mv23) begin
            r_s3_k         <= w_k;
            r_s3_judge     <= (r_phase == PH_JUDGE);
            r_s3_rise_len  <= r_rise_len;
            r_s3_fall_len  <= r_fall_len;
            r_s3_rise_peak <= r_rise_peak[PEAK_W-1:0];
            r_s3_fall_peak <= w_fall_mag[PEAK_W-1:0];
        end
    end

    // ------------------------------------------------------------------------
    // stage 4: lobe areas, length times peak
    // ------------------------------------------------------------------------
    logic signed [SLOPE_W-1:0] r_s4_k;
    logic                      r_s4_judge;
    logic [CNT_W-1:0]          r_s4_rise_len, r_s4_fall_len;
    logic [PEAK_W-1:0]         r_s4_rise_peak;
    logic [AREA_W-1:0]         r_s4_rise_area, r_s4_fall_area;

    always_ff @(posedge i_clk) begin
        if (w_mv34) begin
            r_s4_k         <= r_s3_k;
            r_s4_judge     <= r_s3_judge;
            r_s4_rise_len  <= r_s3_rise_len;
            r_s4_fall_len  <= r_s3_fall_len;
            r_s4_rise_peak <= r_s3_rise_peak;
            r_s4_rise_area <= AREA_W'(r_s3_rise_len) * AREA_W'(r_s3_rise_peak);
            r_s4_fall_area <= AREA_W'(r_s3_fall_len) * AREA_W'(r_s3_fall_peak);
        end
    end

    // ------------------------------------------------------------------------
    // stage 5: threshold checks into the output register
    // ------------------------------------------------------------------------
    logic [TOT_W-1:0]  w_total_len;
    logic [AREA_W:0]   w_sum_area;
    logic              w_len_ok, w_area_ok, w_peak_ok, w_step;
    logic              r_out_step;
    logic signed [SLOPE_W-1:0] r_out_slope;

    assign w_total_len = TOT_W'(r_s4_rise_len) + TOT_W'(r_s4_fall_len);
    assign w_sum_area  = (AREA_W + 1)'(r_s4_rise_area) + (AREA_W + 1)'(r_s4_fall_area);

    assign w_len_ok = (r_s4_rise_len > r_cfg_min_lobe_len)
                   && (r_s4_fall_len > r_cfg_min_lobe_len)
                   && (r_s4_rise_len < r_cfg_max_lobe_len)
                   && (r_s4_fall_len < r_cfg_max_lobe_len)
                   && (w_total_len >= r_cfg_min_total_len);

    assign w_area_ok = (CMP_A_W'(r_s4_rise_area) > CMP_A_W'(r_cfg_min_lobe_area))
                    && (CMP_A_W'(r_s4_fall_area) > CMP_A_W'(r_cfg_min_lobe_area))
                    && (CMP_A_W'(w_sum_area)     > CMP_A_W'(r_cfg_min_sum_area));

    assign w_peak_ok = CMP_P_W'(r_s4_rise_peak) >= CMP_P_W'(r_cfg_min_peak);

    assign w_step = r_s4_judge && w_len_ok && w_area_ok && w_peak_ok;

    always_ff @(posedge i_clk) begin
        if (w_mv45) begin
            r_out_step  <= w_step;
            r_out_slope <= r_s4_k;
        end
    end

    assign o_step_detected = r_out_step;
    assign o_slope_out     = r_out_slope;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
`ifndef ASSERT_OFF
    // input only stalls when every stage is full and the output is held
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_v1 && r_v2 && r_v3 && r_v4 && r_out_valid && i_out_stall))
        else $error("input stalled with room in the pipeline");

    // a blocked average beat keeps its value
    a_avg_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !w_rdy3) |=> (r_v2 && $stable(r_avg)))
        else $error("average stage changed while blocked");

    // rising peak never negative, falling peak never positive
    a_peak_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_rise_peak[SLOPE_W-1] && (r_fall_peak[SLOPE_W-1] || r_fall_peak == '0))
        else $error("lobe peak of wrong sign");

    // flat run inside a rise never passes the lobe end count
    a_rise_flat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_RISE) |-> (r_flat_count <= CNT_W'(FLAT_END)))
        else $error("flat run too long in rising lobe");

    // a judged beat returns to idle and is flagged for the checks
    a_judge_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_mv23 && r_phase == PH_JUDGE) |=> (r_phase == PH_IDLE && r_s3_judge))
        else $error("judge beat did not return to idle");
`endif

endmodule

// File: sim/tb_step_peak_valley_detector_unit.sv
// ----------------------------------------------------------------------------
// tb_step_peak_valley_detector_unit - self-checking bench for the step detector
// drives filtered magnitude samples through the valid/stall channel, predicts
// the deadzoned slope and step flag of every beat, and compares each result
// beat in order; thresholds are reprogrammed over APB between drained phases
// ----------------------------------------------------------------------------
module tb_step_peak_valley_detector_unit;
    import spvd_pkg::*;

    localparam int SBITS         = SAMPLE_BITS_DEF;
    localparam int WLEN          = WINDOW_LEN_DEF;
    localparam int BLOCK_LATENCY = 5;
    localparam int SETTLE_CYCLES = BLOCK_LATENCY + 3;
    localparam int LIMIT_CYCLES  = 900000;
    localparam int SAMPLE_MIN    = -(1 << (SBITS - 1));
    localparam int SAMPLE_MAX    = (1 << (SBITS - 1)) - 1;

    // one predicted result beat
    typedef struct packed {
        logic              step;
        logic signed [SBITS:0] slope;
    } t_step_result;

    // dut ports
    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic signed [SBITS-1:0] i_fir_output;
    logic                    o_out_valid;
    logic                    i_out_stall;
    logic                    o_step_detected;
    logic signed [SBITS:0]   o_slope_out;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [APB_ADDR_W-1:0]   paddr;
    logic [APB_DATA_W-1:0]   pwdata;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;

    // predicted results still owed by the dut, oldest first
    t_step_result pending_results[$];

    // bench-side copy of the detector state and registers
    logic [31:0]             cfg_q [8];
    int                      avg_win [WLEN];
    int                      win_sum;
    int                      prev_avg;
    t_phase                  lobe_phase;
    logic [CNT_W-1:0]        rise_len;
    logic [CNT_W-1:0]        fall_len;
    logic [CNT_W-1:0]        flat_cnt;
    logic signed [SBITS:0]   rise_pk;
    logic signed [SBITS:0]   fall_pk;

    // idling control, percent chance per item (sender) or per cycle (receiver)
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    int          hold_request = 0;

    int          error_count = 0;
    int unsigned beats_sent = 0;
    int unsigned cycle_count = 0;

    step_peak_valley_detector_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_fir_output    (i_fir_output),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_step_detected (o_step_detected),
        .o_slope_out     (o_slope_out),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // 4 time unit clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // run watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("[step_peak_valley_detector_unit] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // detector prediction
    // ------------------------------------------------------------------

    function automatic int reg_bits(input logic [REG_IDX_W-1:0] idx);
        case (idx)
            REG_SLOPE_THR:     return W_SLOPE_THR;
            REG_MIN_LOBE_LEN:  return W_MIN_LOBE_LEN;
            REG_MAX_LOBE_LEN:  return W_MAX_LOBE_LEN;
            REG_MIN_TOTAL_LEN: return W_MIN_TOTAL_LEN;
            REG_MIN_LOBE_AREA: return W_MIN_LOBE_AREA;
            REG_MIN_SUM_AREA:  return W_MIN_SUM_AREA;
            REG_MIN_PEAK:      return W_MIN_PEAK;
            default:           return W_QUIET_LIMIT;
        endcase
    endfunction

    // state after reset: default thresholds, empty window, idle tracker
    function automatic void clear_detector_model();
        int i;
        cfg_q[REG_SLOPE_THR]     = 32'(RST_SLOPE_THR);
        cfg_q[REG_MIN_LOBE_LEN]  = 32'(RST_MIN_LOBE_LEN);
        cfg_q[REG_MAX_LOBE_LEN]  = 32'(RST_MAX_LOBE_LEN);
        cfg_q[REG_MIN_TOTAL_LEN] = 32'(RST_MIN_TOTAL_LEN);
        cfg_q[REG_MIN_LOBE_AREA] = 32'(RST_MIN_LOBE_AREA);
        cfg_q[REG_MIN_SUM_AREA]  = 32'(RST_MIN_SUM_AREA);
        cfg_q[REG_MIN_PEAK]      = 32'(RST_MIN_PEAK);
        cfg_q[REG_QUIET_LIMIT]   = 32'(RST_QUIET_LIMIT);
        for (i = 0; i < WLEN; i++)
            avg_win[i] = 0;
        win_sum    = 0;
        prev_avg   = 0;
        lobe_phase = PH_IDLE;
        rise_len   = '0;
        fall_len   = '0;
        flat_cnt   = '0;
        rise_pk    = '0;
        fall_pk    = '0;
    endfunction

    // counters hold at all ones
    function automatic logic [CNT_W-1:0] count_hold(input logic [CNT_W-1:0] v);
        return (&v) ? v : v + 16'd1;
    endfunction

    // lengths, areas and peak against the thresholds
    function automatic logic lobes_qualify();
        longint area_rise;
        longint area_fall;
        area_rise = longint'(rise_len) * longint'(rise_pk);
        area_fall = -(longint'(fall_len) * longint'(fall_pk));
        return rise_len > cfg_q[REG_MIN_LOBE_LEN] && fall_len > cfg_q[REG_MIN_LOBE_LEN] &&
               rise_len < cfg_q[REG_MAX_LOBE_LEN] && fall_len < cfg_q[REG_MAX_LOBE_LEN] &&
               (longint'(rise_len) + longint'(fall_len)) >=
                   longint'(cfg_q[REG_MIN_TOTAL_LEN]) &&
               area_rise > longint'(cfg_q[REG_MIN_LOBE_AREA]) &&
               area_fall > longint'(cfg_q[REG_MIN_LOBE_AREA]) &&
               (area_rise + area_fall) > longint'(cfg_q[REG_MIN_SUM_AREA]) &&
               longint'(rise_pk) >= longint'(cfg_q[REG_MIN_PEAK]);
    endfunction

    // advance the model by one accepted sample and return its result beat
    function automatic t_step_result predict_step(input logic signed [SBITS-1:0] x);
        t_step_result res;
        int           i;
        int           avg;
        int           k;
        int           thr;
        logic         rising;
        logic         falling;
        res.step = 1'b0;

        // moving average, truncating toward zero
        win_sum = win_sum - avg_win[0];
        for (i = 0; i < WLEN - 1; i++)
            avg_win[i] = avg_win[i + 1];
        avg_win[WLEN - 1] = int'(x);
        win_sum = win_sum + int'(x);
        avg = win_sum / WLEN;

        // slope with the one-count deadzone
        k = avg - prev_avg;
        prev_avg = avg;
        if (k == 1 || k == -1)
            k = 0;

        thr     = int'(cfg_q[REG_SLOPE_THR]);
        rising  = (k >= thr);
        falling = (k <= -thr);

        case (lobe_phase)
            PH_IDLE: begin
                rise_len = '0;
                fall_len = '0;
                rise_pk  = '0;
                fall_pk  = '0;
                flat_cnt = '0;
                if (rising)
                    lobe_phase = PH_RISE;
            end
            PH_RISE: begin
                if (rising) begin
                    rise_len = count_hold(rise_len);
                    if (k > rise_pk)
                        rise_pk = k[SBITS:0];
                end else if (!falling) begin
                    rise_len = count_hold(rise_len);
                    flat_cnt = count_hold(flat_cnt);
                    if (flat_cnt > FLAT_END)
                        lobe_phase = PH_QUIET;
                end else begin
                    lobe_phase = PH_FALL;
                end
            end
            PH_QUIET: begin
                if (!rising && !falling) begin
                    flat_cnt = count_hold(flat_cnt);
                    if (flat_cnt > cfg_q[REG_QUIET_LIMIT])
                        lobe_phase = PH_IDLE;
                end else if (rising) begin
                    lobe_phase = PH_IDLE;
                end else begin
                    flat_cnt   = '0;
                    lobe_phase = PH_FALL;
                end
            end
            PH_FALL: begin
                if (falling && !rising) begin
                    fall_len = count_hold(fall_len);
                    if (k < fall_pk)
                        fall_pk = k[SBITS:0];
                end else if (!rising && !falling) begin
                    fall_len = count_hold(fall_len);
                    flat_cnt = count_hold(flat_cnt);
                    if (flat_cnt > FLAT_END)
                        lobe_phase = PH_JUDGE;
                end else begin
                    lobe_phase = PH_JUDGE;
                end
            end
            PH_JUDGE: begin
                res.step   = lobes_qualify();
                lobe_phase = PH_IDLE;
            end
            default: lobe_phase = PH_IDLE;
        endcase

        res.slope = k[SBITS:0];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d",
                 cycle_count, what, got, want);
        error_count++;
    endtask

    // every accepted result beat is matched against the oldest prediction
    always @(posedge i_clk) begin : result_checker
        t_step_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result beat, slope_out", int'(o_slope_out), 0);
            end else begin
                want = pending_results.pop_front();
                if (o_step_detected !== want.step)
                    report_mismatch("step_detected", int'(o_step_detected), int'(want.step));
                if (o_slope_out !== want.slope)
                    report_mismatch("slope_out", int'(o_slope_out), int'(want.slope));
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver back-pressure
    // ------------------------------------------------------------------

    // random stall bursts, plus a long hold-off on request
    initial begin : out_stall_gen
        int n;
        i_out_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                n = hold_request;
                hold_request = 0;
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (rx_idle_pct > 0 && $urandom_range(0, 99) < rx_idle_pct) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------

    function automatic logic signed [SBITS-1:0] clamp_sample(input int v);
        if (v < SAMPLE_MIN)
            return SBITS'(SAMPLE_MIN);
        if (v > SAMPLE_MAX)
            return SBITS'(SAMPLE_MAX);
        return SBITS'(v);
    endfunction

    // offer one sample beat, hold it until accepted, then predict its result
    task automatic send_sample(input logic signed [SBITS-1:0] x);
        if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_fir_output <= x;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(predict_step(x));
        beats_sent++;
    endtask

    task automatic tx_stop();
        i_in_valid <= 1'b0;
    endtask

    // wait for every owed result, then let the pipeline settle
    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // apb write, bits above the register width carry junk that must be dropped
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
        logic [31:0] mask;
        logic [31:0] word;
        mask = (32'h1 << reg_bits(idx)) - 32'h1;
        word = (value & mask) | ($urandom & ~mask);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        cfg_q[idx] = word & mask;
        // the bus returns to idle between transfers
        @(posedge i_clk);
    endtask

    // stride-shaped magnitude: ramp up, hold, ramp down, tail, with optional noise
    task automatic send_stride(input int base, input int rise_n, input int rise_step,
                               input int hold_n, input int fall_n, input int fall_step,
                               input int tail_n, input int noise);
        int lvl;
        int i;
        int jitter;
        lvl = base;
        for (i = 0; i < rise_n + hold_n + fall_n + tail_n; i++) begin
            if (i < rise_n)
                lvl = lvl + rise_step;
            else if (i >= rise_n + hold_n && i < rise_n + hold_n + fall_n)
                lvl = lvl - fall_step;
            lvl = int'(clamp_sample(lvl));
            jitter = 0;
            if (noise > 0)
                jitter = int'($urandom_range(0, 2 * noise)) - noise;
            send_sample(clamp_sample(lvl + jitter));
        end
    endtask

    // full-range junk samples
    task automatic send_junk(input int n);
        repeat (n) send_sample(SBITS'($urandom));
    endtask

    // mostly stride shapes with random content, some junk and broken strides
    task automatic send_random_mix(input int unsigned quota);
        int unsigned stop_at;
        int          pick;
        stop_at = beats_sent + quota;
        while (beats_sent < stop_at) begin
            pick = $urandom_range(0, 9);
            if (pick < 8) begin
                send_stride(int'($urandom_range(0, 2500)) - 3000,
                            $urandom_range(3, 30), $urandom_range(10, 300),
                            $urandom_range(0, 30),
                            $urandom_range(3, 30), $urandom_range(10, 300),
                            $urandom_range(0, 25),
                            (pick == 0) ? $urandom_range(1, 60) : $urandom_range(0, 8));
            end else if (pick == 8) begin
                send_junk($urandom_range(4, 20));
            end else begin
                // rise that never falls, sometimes followed by a second rise out of the quiet run
                send_stride(-2000, $urandom_range(3, 20), $urandom_range(50, 250),
                            $urandom_range(10, 45), 0, 0, 0, $urandom_range(0, 4));
                if ($urandom_range(0, 1))
                    send_stride(-2000, $urandom_range(3, 20), $urandom_range(50, 250),
                                $urandom_range(0, 10), $urandom_range(3, 20),
                                $urandom_range(50, 250), 10, 0);
            end
        end
    endtask

    // tame thresholds, or random full-width values
    task automatic write_random_config(input bit wild);
        write_reg(REG_SLOPE_THR,     wild ? $urandom_range(0, 255) : $urandom_range(2, 12));
        write_reg(REG_MIN_LOBE_LEN,  wild ? $urandom : $urandom_range(0, 5));
        write_reg(REG_MAX_LOBE_LEN,  wild ? $urandom : $urandom_range(30, 120));
        write_reg(REG_MIN_TOTAL_LEN, wild ? $urandom : $urandom_range(0, 25));
        write_reg(REG_MIN_LOBE_AREA, wild ? $urandom : $urandom_range(0, 800));
        write_reg(REG_MIN_SUM_AREA,  wild ? $urandom : $urandom_range(0, 2000));
        write_reg(REG_MIN_PEAK,      wild ? $urandom : $urandom_range(0, 40));
        write_reg(REG_QUIET_LIMIT,   wild ? $urandom : $urandom_range(0, 40));
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // full-scale samples and a short stride at the reset thresholds
    task automatic test_directed_extremes();
        send_sample(SBITS'(SAMPLE_MIN));
        send_sample(SBITS'(SAMPLE_MIN));
        send_sample(SBITS'(SAMPLE_MAX));
        send_sample(SBITS'(SAMPLE_MAX));
        send_sample(SBITS'(0));
        send_sample(SBITS'(-1));
        send_sample(SBITS'(1));
        send_sample(SBITS'(SAMPLE_MIN));
        send_stride(-1500, 6, 250, 0, 6, 250, 5, 0);
        tx_stop();
        wait_drained();
    endtask

    // every register at its strictest setting, then at or near its most lenient
    task automatic test_register_extremes();
        write_reg(REG_SLOPE_THR,     32'hFFFF_FFFF);
        write_reg(REG_MIN_LOBE_LEN,  32'hFFFF_FFFF);
        write_reg(REG_MAX_LOBE_LEN,  32'h0);
        write_reg(REG_MIN_TOTAL_LEN, 32'hFFFF_FFFF);
        write_reg(REG_MIN_LOBE_AREA, 32'hFFFF_FFFF);
        write_reg(REG_MIN_SUM_AREA,  32'hFFFF_FFFF);
        write_reg(REG_MIN_PEAK,      32'hFFFF_FFFF);
        write_reg(REG_QUIET_LIMIT,   32'h0);
        // full-scale swings give slopes beyond the widest threshold
        send_stride(SAMPLE_MIN, 2, 4095, 20, 2, 4095, 20, 0);
        tx_stop();
        wait_drained();

        write_reg(REG_SLOPE_THR,     32'h1);
        write_reg(REG_MIN_LOBE_LEN,  32'h0);
        write_reg(REG_MAX_LOBE_LEN,  32'hFFFF_FFFF);
        write_reg(REG_MIN_TOTAL_LEN, 32'h0);
        write_reg(REG_MIN_LOBE_AREA, 32'h0);
        write_reg(REG_MIN_SUM_AREA,  32'h0);
        write_reg(REG_MIN_PEAK,      32'h0);
        write_reg(REG_QUIET_LIMIT,   32'hFFFF_FFFF);
        send_stride(-2000, 20, 120, 10, 20, 120, 30, 2);
        tx_stop();
        wait_drained();
    endtask

    // long flat runs with a zero slope threshold and the widest quiet limit
    task automatic test_long_runs();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        // zero threshold: a constant input counts as rising
        write_reg(REG_SLOPE_THR, 32'h0);
        send_stride(1000, 0, 0, 40, 20, 250, 10, 0);
        tx_stop();
        wait_drained();
        // widest quiet limit: the flat run only ends on a slope
        write_reg(REG_SLOPE_THR,   32'd5);
        write_reg(REG_QUIET_LIMIT, 32'hFFFF);
        send_stride(-3000, 15, 200, 40, 15, 200, 20, 0);
        tx_stop();
        wait_drained();
    endtask

    // several random phases, each with its own thresholds and idling
    task automatic test_random_strides();
        int p;
        for (p = 0; p < 6; p++) begin
            write_random_config(p == 3);
            tx_idle_pct = (p == 0) ? 0 : $urandom_range(5, 35);
            rx_idle_pct = (p == 0) ? 0 : $urandom_range(2, 12);
            send_random_mix(20);
            tx_stop();
            wait_drained();
        end
    endtask

    // receiver holds off long enough for the pipeline to fill and stall input
    task automatic test_output_hold();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_request = 60;
        wait (hold_request == 0);
        send_stride(-2000, 12, 150, 4, 12, 150, 10, 3);
        tx_stop();
        wait_drained();
    endtask

    // sender pauses mid-stride until every result is back
    task automatic test_drain_pause();
        tx_idle_pct = 20;
        rx_idle_pct = 8;
        send_stride(-2500, 18, 140, 0, 0, 0, 0, 2);
        tx_stop();
        wait_drained();
        send_stride(0, 0, 0, 6, 18, 140, 20, 2);
        tx_stop();
        wait_drained();
    endtask

    // closing stretch at full rate
    task automatic test_full_rate_tail();
        write_random_config(1'b0);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_random_mix(30);
        tx_stop();
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial begin : stimulus
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_fir_output <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        clear_detector_model();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_extremes();
        test_register_extremes();
        test_long_runs();
        test_random_strides();
        test_output_hold();
        test_drain_pause();
        test_full_rate_tail();

        if (error_count == 0 && pending_results.size() == 0) begin
            $display("[step_peak_valley_detector_unit] OK");
        end else begin
            $display("[step_peak_valley_detector_unit] ERROR");
        end
        $finish;
    end

endmodule
